[rtl/set_assoc_cache_nru_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache with NRU replacement
// Shared property wrappers, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_NRU_DEFINES_SVH
`define SET_ASSOC_CACHE_NRU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SACN_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SACN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sacn_pkg.sv]
// ----------------------------------------------------------------------------
// sacn_pkg
// Geometry, widths, register indexes and types of the NRU cache model.
// ----------------------------------------------------------------------------
package sacn_pkg;

	localparam int MAX_SETS  = 256;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_BITS = 32;

	localparam int SET_W  = $clog2(MAX_SETS);
	localparam int WAY_W  = $clog2(MAX_WAYS);
	localparam int FILL_W = $clog2(MAX_WAYS + 1);
	localparam int TAG_W  = ADDR_BITS;
	localparam int CNT_W  = 32;

	// Configuration registers.
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CFG_W;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

	localparam logic [CFG_W-1:0] BLOCK_BITS_RST = 4'd5;
	localparam logic [CFG_W-1:0] SET_BITS_RST   = 4'd6;
	localparam logic [CFG_W-1:0] WAYS_USED_RST  = 4'd8;
	localparam logic [CFG_W-1:0] BLOCK_BITS_MAX = 4'd12;
	localparam logic [CFG_W-1:0] SET_BITS_MAX   = 4'd12;

	typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef struct packed {
		logic [FILL_W-1:0]   fill;
		logic [MAX_WAYS-1:0] nru;
	} meta_t;

endpackage

[rtl/sacn_if.sv]
// ----------------------------------------------------------------------------
// Cache channel interfaces
// Request channel (address, access kind) and response channel (hit, way,
// running counters), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sacn_req_if;
	import sacn_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] address;
	logic                 is_write;

	modport source (output valid, output address, output is_write, input ready);
	modport sink (input valid, input address, input is_write, output ready);
endinterface

interface sacn_rsp_if;
	import sacn_pkg::*;

	logic             valid;
	logic             ready;
	logic             hit;
	logic [WAY_W-1:0] way;
	logic [CNT_W-1:0] read_count;
	logic [CNT_W-1:0] write_count;
	logic [CNT_W-1:0] read_hits;
	logic [CNT_W-1:0] write_hits;
	logic [CNT_W-1:0] read_misses;
	logic [CNT_W-1:0] write_misses;
	logic [CNT_W-1:0] total_hits;
	logic [CNT_W-1:0] total_misses;

	modport source (output valid, output hit, output way, output read_count,
		output write_count, output read_hits, output write_hits,
		output read_misses, output write_misses, output total_hits,
		output total_misses, input ready);
	modport sink (input valid, input hit, input way, input read_count,
		input write_count, input read_hits, input write_hits,
		input read_misses, input write_misses, input total_hits,
		input total_misses, output ready);
endinterface

[rtl/set_assoc_cache_nru.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_nru
// Tag lookup of a set-associative cache with not-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
// Each request item carries a byte address and a read/write flag. The address
// is cut into block offset, set index and tag using the block_bits and
// set_bits registers; the tag is compared against the filled ways of its set.
// Each request yields exactly one response item with the hit flag, the way that
// hit, was filled or was replaced, and the running access/hit/miss counters
// after this access (all counters wrap at 2^32).
// Timing: an accepted item is registered into the lookup stage; it is looked
// up and written back once the output register is free, and its response is
// registered at the same edge. The block takes no new item until the last one
// is written back, owing to the read-modify-write of the set's tag row and
// NRU metadata in the tag and metadata memories (read in the accept cycle,
// written in the write-back cycle). Since ready is low during write-back, a
// following item always reads the updated set and no forwarding is needed.
// If the receiver stalls, the response waits in the output register; one more
// item may be accepted meanwhile and holds in its lookup cycle, without any
// state change, until the output register is free.
// Reset clears the counters, restores the registers to 5, 6 and 8, and clears
// a per-set valid flag so every set reads as empty; tags are never reset.
// Configuration writes take effect at once and must only be issued while idle.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_nru_defines.svh"

module set_assoc_cache_nru (
	input  logic                           clk,
	input  logic                           arst_n,
	sacn_req_if.sink                       req,
	sacn_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [sacn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacn_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sacn_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0] block_bits_q;
	logic [CFG_W-1:0] set_bits_q;
	logic [CFG_W-1:0] ways_used_q;

	// Storage: tag rows and per-set metadata, plus a valid flag per set
	// so that reset empties every set at once.
	tag_row_t          tag_mem [MAX_SETS];
	meta_t             meta_mem [MAX_SETS];
	logic [MAX_SETS-1:0] meta_vld_q;

	tag_row_t          tag_rd_q;
	meta_t             meta_rd_q;

	// Lookup stage registers.
	logic              busy_q;
	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              wr_s1;
	logic              vld_s1;

	// Running counters.
	logic [CNT_W-1:0]  reads_q;
	logic [CNT_W-1:0]  writes_q;
	logic [CNT_W-1:0]  rd_hits_q;
	logic [CNT_W-1:0]  wr_hits_q;
	logic [CNT_W-1:0]  rd_miss_q;
	logic [CNT_W-1:0]  wr_miss_q;

	// Output register.
	logic              out_vld_q;
	logic              out_hit_q;
	logic [WAY_W-1:0]  out_way_q;
	logic [CNT_W-1:0]  out_tot_hits_q;
	logic [CNT_W-1:0]  out_tot_miss_q;

	// Address split at acceptance.
	logic              acc;
	logic [CFG_W-1:0]  bb_eff;
	logic [CFG_W-1:0]  sb_eff;
	logic [CFG_W:0]    tag_shift;
	logic [ADDR_BITS-1:0] blk_c;
	logic [SET_W-1:0]  set_mask;
	logic [SET_W-1:0]  set_c;
	logic [TAG_W-1:0]  tag_c;

	// Lookup and update.
	logic              fin;
	logic [FILL_W-1:0] fill_cur;
	logic [FILL_W-1:0] wu_eff;
	logic [MAX_WAYS-1:0] filled_mask;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] nru_cur;
	logic [MAX_WAYS-1:0] cand;
	logic [MAX_WAYS-1:0] nru_new;
	logic [FILL_W-1:0] fill_new;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  cand_way;
	logic [WAY_W-1:0]  way_c;
	logic              hit_c;
	logic              tag_we;
	logic [CNT_W-1:0]  reads_nx;
	logic [CNT_W-1:0]  writes_nx;
	logic [CNT_W-1:0]  rd_hits_nx;
	logic [CNT_W-1:0]  wr_hits_nx;
	logic [CNT_W-1:0]  rd_miss_nx;
	logic [CNT_W-1:0]  wr_miss_nx;

	assign req.ready = !busy_q;
	assign acc       = req.valid && !busy_q;
	assign fin       = busy_q && (!out_vld_q || rsp.ready);

	// Sizes above the supported range are clamped to it.
	always_comb begin
		bb_eff    = (block_bits_q > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_q;
		sb_eff    = (set_bits_q > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_q;
		tag_shift = {1'b0, bb_eff} + {1'b0, sb_eff};
		blk_c     = req.address >> bb_eff;
		if (sb_eff >= CFG_W'(SET_W)) begin
			set_mask = '1;
		end else begin
			set_mask = ~({SET_W{1'b1}} << sb_eff);
		end
		set_c = blk_c[SET_W-1:0] & set_mask;
		tag_c = TAG_W'(req.address >> tag_shift);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bits_q <= BLOCK_BITS_RST;
			set_bits_q   <= SET_BITS_RST;
			ways_used_q  <= WAYS_USED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_BITS: block_bits_q <= cfg_data;
				CFG_SET_BITS:   set_bits_q   <= cfg_data;
				CFG_WAYS_USED:  ways_used_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memory reads happen only in the accept cycle, writes only in the
	// write-back cycle, so the two never touch the memories together.
	always_ff @(posedge clk) begin
		if (acc) begin
			tag_rd_q  <= tag_mem[set_c];
			meta_rd_q <= meta_mem[set_c];
		end
		if (fin) begin
			if (tag_we) begin
				tag_mem[set_s1][way_c] <= tag_s1;
			end
			meta_mem[set_s1] <= '{fill: fill_new, nru: nru_new};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			set_s1 <= set_c;
			tag_s1 <= tag_c;
			wr_s1  <= req.is_write;
			vld_s1 <= meta_vld_q[set_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			meta_vld_q <= '0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (fin) begin
				meta_vld_q[set_s1] <= 1'b1;
			end
		end
	end

	// Tag compare over the filled ways and NRU victim choice.
	always_comb begin
		fill_cur = vld_s1 ? meta_rd_q.fill : '0;
		if (fill_cur > FILL_W'(MAX_WAYS)) begin
			fill_cur = FILL_W'(MAX_WAYS);
		end
		if (ways_used_q == '0) begin
			wu_eff = FILL_W'(1);
		end else if (ways_used_q > CFG_W'(MAX_WAYS)) begin
			wu_eff = FILL_W'(MAX_WAYS);
		end else begin
			wu_eff = FILL_W'(ways_used_q);
		end
		nru_cur = vld_s1 ? meta_rd_q.nru : '0;

		for (int w = 0; w < MAX_WAYS; w++) begin
			filled_mask[w] = FILL_W'(w) < fill_cur;
			match[w]       = filled_mask[w] && (tag_rd_q[w] == tag_s1);
		end
		cand  = nru_cur & filled_mask;
		hit_c = |match;

		// Lowest way wins.
		hit_way  = '0;
		cand_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (cand[w]) begin
				cand_way = WAY_W'(w);
			end
		end

		nru_new  = nru_cur;
		fill_new = fill_cur;
		tag_we   = 1'b0;
		way_c    = '0;
		if (hit_c) begin
			way_c = hit_way;
		end else if (fill_cur < wu_eff) begin
			way_c    = WAY_W'(fill_cur);
			fill_new = fill_cur + FILL_W'(1);
			tag_we   = 1'b1;
		end else begin
			tag_we = 1'b1;
			if (|cand) begin
				way_c = cand_way;
			end else begin
				nru_new = nru_cur | filled_mask;
				way_c   = '0;
			end
		end
		nru_new[way_c] = 1'b0;
	end

	always_comb begin
		reads_nx   = reads_q;
		writes_nx  = writes_q;
		rd_hits_nx = rd_hits_q;
		wr_hits_nx = wr_hits_q;
		rd_miss_nx = rd_miss_q;
		wr_miss_nx = wr_miss_q;
		if (wr_s1) begin
			writes_nx = writes_q + CNT_W'(1);
			if (hit_c) begin
				wr_hits_nx = wr_hits_q + CNT_W'(1);
			end else begin
				wr_miss_nx = wr_miss_q + CNT_W'(1);
			end
		end else begin
			reads_nx = reads_q + CNT_W'(1);
			if (hit_c) begin
				rd_hits_nx = rd_hits_q + CNT_W'(1);
			end else begin
				rd_miss_nx = rd_miss_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_q   <= '0;
			writes_q  <= '0;
			rd_hits_q <= '0;
			wr_hits_q <= '0;
			rd_miss_q <= '0;
			wr_miss_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (fin) begin
				reads_q   <= reads_nx;
				writes_q  <= writes_nx;
				rd_hits_q <= rd_hits_nx;
				wr_hits_q <= wr_hits_nx;
				rd_miss_q <= rd_miss_nx;
				wr_miss_q <= wr_miss_nx;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// The counter registers themselves hold the reported values after a
	// write-back, so only the derived fields need their own registers.
	always_ff @(posedge clk) begin
		if (fin) begin
			out_hit_q      <= hit_c;
			out_way_q      <= way_c;
			out_tot_hits_q <= rd_hits_nx + wr_hits_nx;
			out_tot_miss_q <= rd_miss_nx + wr_miss_nx;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.hit          = out_hit_q;
	assign rsp.way          = out_way_q;
	assign rsp.read_count   = reads_q;
	assign rsp.write_count  = writes_q;
	assign rsp.read_hits    = rd_hits_q;
	assign rsp.write_hits   = wr_hits_q;
	assign rsp.read_misses  = rd_miss_q;
	assign rsp.write_misses = wr_miss_q;
	assign rsp.total_hits   = out_tot_hits_q;
	assign rsp.total_misses = out_tot_miss_q;

	`SACN_ASSERT_NEXT(a_acc_then_busy, clk, arst_n, acc, busy_q && !req.ready, "accepted item did not enter lookup")
	`SACN_ASSERT_SAME(a_hit_in_filled, clk, arst_n, fin && hit_c, FILL_W'(way_c) < fill_cur, "hit on a way that is not filled")
	`SACN_ASSERT_SAME(a_fill_bound, clk, arst_n, fin, fill_new <= FILL_W'(MAX_WAYS) && !nru_new[way_c], "bad metadata write-back")
	`SACN_ASSERT_NEXT(a_one_access, clk, arst_n, fin, (reads_q + writes_q) == ($past(reads_q + writes_q) + CNT_W'(1)), "access counters did not advance by one")

endmodule
